FILE: src/qdpr_pkg.sv
package qdpr_pkg;

	// Queue between the accumulate front and the requantize back (power of two)
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [FIFO_AW:0]   fifo_cnt_t;
	typedef logic [FIFO_AW-1:0] fifo_ptr_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_INPUT_OFFSET     = 3'd0,
		REG_WEIGHT_OFFSET    = 3'd1,
		REG_RESULT_OFFSET    = 3'd2,
		REG_SCALE_MULTIPLIER = 3'd3,
		REG_SCALE_SHIFT      = 3'd4,
		REG_CLAMP_LOW        = 3'd5,
		REG_CLAMP_HIGH       = 3'd6,
		REG_NARROW_TO_BYTE   = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [7:0]  input_offset;
		logic [7:0]  weight_offset;
		logic [7:0]  result_offset;
		logic [31:0] scale_multiplier;
		logic [5:0]  scale_shift;
		logic [7:0]  clamp_low;
		logic [7:0]  clamp_high;
		logic        narrow_to_byte;
	} cfg_t;

	// Finished dot product waiting for requantization
	typedef struct packed {
		logic        valid;
		logic [31:0] data;
	} acc_item_t;

	// Saturate a wide signed value to int16
	function automatic logic [15:0] sat16(input logic signed [63:0] v);
		logic [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -64'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: src/qdpr_if.sv
// Input channel: one byte pair per item
interface qdpr_pair_if;
	logic        valid;
	logic        ready;
	logic [7:0]  activation;
	logic [7:0]  weight;
	logic [31:0] channel_bias;
	logic        first;
	logic        last;

	modport source(output valid, activation, weight, channel_bias, first, last, input ready);
	modport sink(input valid, activation, weight, channel_bias, first, last, output ready);
endinterface

// Output channel: one requantized value per item
interface qdpr_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] result;

	modport source(output valid, result, input ready);
	modport sink(input valid, result, output ready);
endinterface

FILE: src/quantized_dot_product_requantize.sv
// A last item goes through the front product register, the result queue and the
// requantize product, high word, int16 and output registers to the output.
// Throughput: one byte pair per cycle; the accumulate loop closes in one 32-bit add.
// A 4-entry queue holds finished dot products, so output stalls do not stop input
// until the queue is full; requantize moves one result per cycle while not stalled.
// Reset: arst_n clears the accumulator, queue and valid flags and loads the
// register defaults; no clearing pass.
module quantized_dot_product_requantize (
	input  logic          clk,
	input  logic          arst_n,
	qdpr_pair_if.sink     pairs,
	qdpr_result_if.source results,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	qdpr_pkg::cfg_t      cfg_q;
	qdpr_pkg::acc_item_t push;
	qdpr_pkg::acc_item_t head;
	qdpr_pkg::fifo_cnt_t fifo_count;
	logic                pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_offset     <= 8'd0;
			cfg_q.weight_offset    <= 8'd0;
			cfg_q.result_offset    <= 8'd0;
			cfg_q.scale_multiplier <= 32'h4000_0000;
			cfg_q.scale_shift      <= 6'd0;
			cfg_q.clamp_low        <= 8'd0;
			cfg_q.clamp_high       <= 8'hFF;
			cfg_q.narrow_to_byte   <= 1'b1;
		end else if (cfg_we) begin
			unique case (qdpr_pkg::reg_index_t'(cfg_index))
				qdpr_pkg::REG_INPUT_OFFSET:     cfg_q.input_offset     <= cfg_data[7:0];
				qdpr_pkg::REG_WEIGHT_OFFSET:    cfg_q.weight_offset    <= cfg_data[7:0];
				qdpr_pkg::REG_RESULT_OFFSET:    cfg_q.result_offset    <= cfg_data[7:0];
				qdpr_pkg::REG_SCALE_MULTIPLIER: cfg_q.scale_multiplier <= cfg_data;
				qdpr_pkg::REG_SCALE_SHIFT:      cfg_q.scale_shift      <= cfg_data[5:0];
				qdpr_pkg::REG_CLAMP_LOW:        cfg_q.clamp_low        <= cfg_data[7:0];
				qdpr_pkg::REG_CLAMP_HIGH:       cfg_q.clamp_high       <= cfg_data[7:0];
				qdpr_pkg::REG_NARROW_TO_BYTE:   cfg_q.narrow_to_byte   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	qdpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pairs      (pairs),
		.cfg        (cfg_q),
		.fifo_count (fifo_count),
		.push       (push)
	);

	qdpr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (fifo_count)
	);

	qdpr_requant u_requant (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

	// Queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= qdpr_pkg::fifo_cnt_t'(qdpr_pkg::FIFO_DEPTH))
		else $error("result queue over capacity");

	// A push into a full queue must not happen
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> fifo_count != qdpr_pkg::fifo_cnt_t'(qdpr_pkg::FIFO_DEPTH))
		else $error("push into full result queue");

	// Byte mode results fit in the low byte
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && cfg_q.narrow_to_byte) |-> results.result[15:8] == 8'd0)
		else $error("byte mode result out of range");

endmodule

FILE: src/qdpr_front.sv
module qdpr_front (
	input  logic                clk,
	input  logic                arst_n,
	qdpr_pair_if.sink           pairs,
	input  qdpr_pkg::cfg_t      cfg,
	input  qdpr_pkg::fifo_cnt_t fifo_count,
	output qdpr_pkg::acc_item_t push
);

	logic               v_s1;
	logic               first_s1;
	logic               last_s1;
	logic [31:0]        bias_s1;
	logic signed [17:0] prod_s1;
	logic [31:0]        acc_q;
	logic [31:0]        acc_next;
	logic signed [8:0]  a_c;
	logic signed [8:0]  w_c;
	logic               pend;
	logic               take;

	// Room check: a queue slot must be free for anything already in flight
	assign pend        = v_s1 & last_s1;
	assign pairs.ready = (fifo_count + qdpr_pkg::fifo_cnt_t'(pend))
		< qdpr_pkg::fifo_cnt_t'(qdpr_pkg::FIFO_DEPTH);
	assign take        = pairs.valid & pairs.ready;

	// Zero-point corrected operands
	assign a_c = $signed({1'b0, pairs.activation}) - $signed({1'b0, cfg.input_offset});
	assign w_c = $signed({1'b0, pairs.weight}) - $signed({1'b0, cfg.weight_offset});

	// Stage 1: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1  <= a_c * w_c;
			first_s1 <= pairs.first;
			last_s1  <= pairs.last;
			bias_s1  <= pairs.channel_bias;
		end
	end

	// Stage 2: wrapping accumulate, last item goes to the queue
	assign acc_next = (first_s1 ? bias_s1 : acc_q) + {{14{prod_s1[17]}}, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_next;
		end
	end

	assign push.valid = pend;
	assign push.data  = acc_next;

endmodule

FILE: src/qdpr_fifo.sv
module qdpr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  qdpr_pkg::acc_item_t push,
	input  logic                pop,
	output qdpr_pkg::acc_item_t head,
	output qdpr_pkg::fifo_cnt_t count
);

	logic [31:0]         mem_q [qdpr_pkg::FIFO_DEPTH];
	qdpr_pkg::fifo_ptr_t wr_ptr_q;
	qdpr_pkg::fifo_ptr_t rd_ptr_q;
	qdpr_pkg::fifo_cnt_t count_q;
	logic                do_pop;

	assign do_pop     = pop & (count_q != '0);
	assign head.valid = count_q != '0;
	assign head.data  = mem_q[rd_ptr_q];
	assign count      = count_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + qdpr_pkg::fifo_cnt_t'(push.valid)
				- qdpr_pkg::fifo_cnt_t'(do_pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

endmodule

FILE: src/qdpr_requant.sv
module qdpr_requant (
	input  logic                clk,
	input  logic                arst_n,
	input  qdpr_pkg::cfg_t      cfg,
	input  qdpr_pkg::acc_item_t head,
	output logic                pop,
	qdpr_result_if.source       results
);

	logic               en;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] prod_s1;
	logic [31:0]        m_s2;
	logic [15:0]        r_s3;
	logic [15:0]        res_s4;

	logic signed [63:0] x_c;
	logic signed [32:0] hi_c;
	logic [31:0]        m_c;

	logic signed [5:0]  sh;
	logic [4:0]         n_c;
	logic [5:0]         neg_c;
	logic [4:0]         k_c;
	logic signed [32:0] rnd_c;
	logic signed [32:0] rsh_c;
	logic signed [63:0] wide_c;

	logic signed [16:0] off_c;
	logic [7:0]         b_sat;
	logic [7:0]         b_lo;
	logic [7:0]         b_c;

	// Whole pipeline advances while the output register can move
	assign en  = !v_s4 | results.ready;
	assign pop = en & head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= head.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 2 logic: round, take high word, saturate to int32
	always_comb begin
		x_c  = prod_s1 + (64'sd1 <<< 30);
		hi_c = x_c[63:31];
		if (hi_c[32] != hi_c[31]) begin
			m_c = hi_c[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			m_c = hi_c[31:0];
		end
	end

	// Stage 3 logic: rounding right shift or exact left shift, then int16
	always_comb begin
		sh     = $signed(cfg.scale_shift);
		n_c    = sh[4:0];
		neg_c  = 6'(~cfg.scale_shift + 6'd1);
		k_c    = neg_c[5] ? 5'd31 : neg_c[4:0];
		rnd_c  = $signed({m_s2[31], m_s2}) + (33'sd1 <<< (n_c - 5'd1));
		rsh_c  = rnd_c >>> n_c;
		if (sh > 6'sd0) begin
			wide_c = {{31{rsh_c[32]}}, rsh_c};
		end else if (sh < 6'sd0) begin
			wide_c = $signed({{32{m_s2[31]}}, m_s2}) <<< k_c;
		end else begin
			wide_c = $signed({{32{m_s2[31]}}, m_s2});
		end
	end

	// Stage 4 logic: byte mode offset, saturation and clamp
	always_comb begin
		off_c = $signed({r_s3[15], r_s3}) + $signed({9'd0, cfg.result_offset});
		if (off_c < 17'sd0) begin
			b_sat = 8'd0;
		end else if (off_c > 17'sd255) begin
			b_sat = 8'hFF;
		end else begin
			b_sat = off_c[7:0];
		end
		b_lo = (b_sat < cfg.clamp_low) ? cfg.clamp_low : b_sat;
		b_c  = (b_lo > cfg.clamp_high) ? cfg.clamp_high : b_lo;
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed(head.data) * $signed(cfg.scale_multiplier);
			m_s2    <= m_c;
			r_s3    <= qdpr_pkg::sat16(wide_c);
			res_s4  <= cfg.narrow_to_byte ? {8'd0, b_c} : r_s3;
		end
	end

	assign results.valid  = v_s4;
	assign results.result = res_s4;

endmodule

FILE: tb/testbench.sv
module testbench;

	localparam int DRAIN_CYCLES  = 12;
	localparam int STALL_LIMIT   = 2000;
	localparam int SEGMENT_ITEMS = 140;
	localparam int SET_LOWEST    = 0;
	localparam int SET_HIGHEST   = 1;
	localparam int SET_RANDOM    = 2;

	// One row of the directed plan: either a register write or a byte pair item
	typedef struct {
		bit                   is_write;
		qdpr_pkg::reg_index_t index;
		logic [31:0]          data;
		logic [7:0]           activation;
		logic [7:0]           weight;
		logic [31:0]          bias;
		bit                   first;
		bit                   last;
		bit                   typed;
		logic [15:0]          typed_result;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	qdpr_pair_if   pairs_ch();
	qdpr_result_if results_ch();

	quantized_dot_product_requantize uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pairs    (pairs_ch),
		.results  (results_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Local copy of the register file and the accumulator
	logic [7:0]         zp_input;
	logic [7:0]         zp_weight;
	logic [7:0]         zp_result;
	logic signed [31:0] scale_mult;
	logic [5:0]         scale_shift;
	logic [7:0]         clamp_lo;
	logic [7:0]         clamp_hi;
	logic               byte_mode;
	logic [31:0]        acc_model;

	logic [15:0] pending_results[$];
	logic [15:0] oldest;
	plan_row_t   directed_plan[$];
	int          mismatches;
	int          items_sent;
	int          directed_items;
	int          results_seen;
	int          settings_used;
	int          src_idle_pct;
	int          snk_idle_pct;
	int          stall_cycles;
	int          seg_start;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Doubling high multiply, rounding shift, int16 saturation, byte mode offset and clamp
	function automatic logic [15:0] requantized(input logic [31:0] acc);
		longint m;
		int     n;
		m = (longint'($signed(acc)) * longint'(scale_mult) + (longint'(1) <<< 30)) >>> 31;
		if (m > 64'sd2147483647)
			m = 64'sd2147483647;
		n = int'($signed(scale_shift));
		if (n > 0)
			m = (m + (longint'(1) <<< (n - 1))) >>> n;
		else if (n < 0)
			m = m <<< ((-n > 31) ? 31 : -n);
		if (m > 32767)
			m = 32767;
		else if (m < -32768)
			m = -32768;
		if (byte_mode) begin
			m = m + longint'(zp_result);
			if (m < 0)
				m = 0;
			else if (m > 255)
				m = 255;
			if (m < longint'(clamp_lo))
				m = longint'(clamp_lo);
			if (m > longint'(clamp_hi))
				m = longint'(clamp_hi);
		end
		return m[15:0];
	endfunction

	// Multiply-accumulate one pair; returns what a result would be if this item ends the vector
	function automatic logic [15:0] accumulate_pair(input logic [7:0] act, input logic [7:0] wt,
			input logic [31:0] bias, input bit first);
		int a;
		int w;
		a = int'(act) - int'(zp_input);
		w = int'(wt) - int'(zp_weight);
		if (first)
			acc_model = bias;
		acc_model = acc_model + 32'(a * w);
		return requantized(acc_model);
	endfunction

	function automatic plan_row_t pair_row(input logic [7:0] act, input logic [7:0] wt,
			input logic [31:0] bias, input bit first, input bit last,
			input bit typed = 1'b0, input logic [15:0] typed_result = 16'h0000);
		plan_row_t r;
		r.is_write     = 1'b0;
		r.index        = qdpr_pkg::REG_INPUT_OFFSET;
		r.data         = 32'd0;
		r.activation   = act;
		r.weight       = wt;
		r.bias         = bias;
		r.first        = first;
		r.last         = last;
		r.typed        = typed;
		r.typed_result = typed_result;
		return r;
	endfunction

	function automatic plan_row_t write_row(input qdpr_pkg::reg_index_t index,
			input logic [31:0] data);
		plan_row_t r;
		r = pair_row(8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
		r.is_write = 1'b1;
		r.index    = index;
		r.data     = data;
		return r;
	endfunction

	// Drive one pair until accepted, then predict
	task automatic send_pair(input logic [7:0] act, input logic [7:0] wt, input logic [31:0] bias,
			input bit first, input bit last, input bit typed, input logic [15:0] typed_result);
		logic [15:0] predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pairs_ch.valid = 1'b0;
			@(negedge clk);
		end
		pairs_ch.valid        = 1'b1;
		pairs_ch.activation   = act;
		pairs_ch.weight       = wt;
		pairs_ch.channel_bias = bias;
		pairs_ch.first        = first;
		pairs_ch.last         = last;
		@(posedge clk);
		while (!pairs_ch.ready)
			@(posedge clk);
		predicted = accumulate_pair(act, wt, bias, first);
		if (last)
			pending_results.push_back(typed ? typed_result : predicted);
		items_sent++;
	endtask

	// Stop sending and wait until every expected result is out and the pipe is quiet
	task automatic settle();
		@(negedge clk);
		pairs_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Called at a falling edge; the write lands on the next rising edge
	task automatic write_reg(input qdpr_pkg::reg_index_t index, input logic [31:0] data);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (index)
			qdpr_pkg::REG_INPUT_OFFSET:     zp_input    = data[7:0];
			qdpr_pkg::REG_WEIGHT_OFFSET:    zp_weight   = data[7:0];
			qdpr_pkg::REG_RESULT_OFFSET:    zp_result   = data[7:0];
			qdpr_pkg::REG_SCALE_MULTIPLIER: scale_mult  = data;
			qdpr_pkg::REG_SCALE_SHIFT:      scale_shift = data[5:0];
			qdpr_pkg::REG_CLAMP_LOW:        clamp_lo    = data[7:0];
			qdpr_pkg::REG_CLAMP_HIGH:       clamp_hi    = data[7:0];
			qdpr_pkg::REG_NARROW_TO_BYTE:   byte_mode   = data[0];
		endcase
	endtask

	// Load a full register setting: all lows but a shift of -31, all highs, or a random mix
	task automatic apply_settings(input int kind);
		logic [31:0] mult;
		logic [5:0]  shift;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  tmp;
		settle();
		settings_used++;
		if (kind == SET_LOWEST) begin
			write_reg(qdpr_pkg::REG_INPUT_OFFSET, 32'd0);
			write_reg(qdpr_pkg::REG_WEIGHT_OFFSET, 32'd0);
			write_reg(qdpr_pkg::REG_RESULT_OFFSET, 32'd0);
			write_reg(qdpr_pkg::REG_SCALE_MULTIPLIER, 32'h8000_0000);
			write_reg(qdpr_pkg::REG_SCALE_SHIFT, 32'h21);
			write_reg(qdpr_pkg::REG_CLAMP_LOW, 32'd0);
			write_reg(qdpr_pkg::REG_CLAMP_HIGH, 32'd0);
			write_reg(qdpr_pkg::REG_NARROW_TO_BYTE, 32'd0);
		end else if (kind == SET_HIGHEST) begin
			write_reg(qdpr_pkg::REG_INPUT_OFFSET, 32'd255);
			write_reg(qdpr_pkg::REG_WEIGHT_OFFSET, 32'd255);
			write_reg(qdpr_pkg::REG_RESULT_OFFSET, 32'd255);
			write_reg(qdpr_pkg::REG_SCALE_MULTIPLIER, 32'h7FFF_FFFF);
			write_reg(qdpr_pkg::REG_SCALE_SHIFT, 32'd31);
			write_reg(qdpr_pkg::REG_CLAMP_LOW, 32'd255);
			write_reg(qdpr_pkg::REG_CLAMP_HIGH, 32'd255);
			write_reg(qdpr_pkg::REG_NARROW_TO_BYTE, 32'd1);
		end else begin
			mult = $urandom();
			case ($urandom_range(0, 3))
				0: ;
				1: mult = 32'h4000_0000 | (mult & 32'h3FFF_FFFF);
				2: mult = 32'h8000_0000 | (mult & 32'h3FFF_FFFF);
				default: mult = mult & 32'h000F_FFFF;
			endcase
			case ($urandom_range(0, 3))
				0, 1: shift = 6'($urandom_range(0, 12));
				2: shift = 6'($urandom());
				default: shift = 6'(64 - $urandom_range(1, 4));
			endcase
			lo = 8'($urandom());
			hi = 8'($urandom());
			// mostly ordered bounds, sometimes crossed
			if (lo > hi && $urandom_range(0, 3) != 0) begin
				tmp = lo;
				lo  = hi;
				hi  = tmp;
			end
			write_reg(qdpr_pkg::REG_INPUT_OFFSET, 32'($urandom_range(0, 255)));
			write_reg(qdpr_pkg::REG_WEIGHT_OFFSET, 32'($urandom_range(0, 255)));
			write_reg(qdpr_pkg::REG_RESULT_OFFSET, 32'($urandom_range(0, 255)));
			write_reg(qdpr_pkg::REG_SCALE_MULTIPLIER, mult);
			write_reg(qdpr_pkg::REG_SCALE_SHIFT, 32'(shift));
			write_reg(qdpr_pkg::REG_CLAMP_LOW, 32'(lo));
			write_reg(qdpr_pkg::REG_CLAMP_HIGH, 32'(hi));
			write_reg(qdpr_pkg::REG_NARROW_TO_BYTE, 32'($urandom_range(0, 1)));
		end
	endtask

	// Well-formed dot product: first item carries the bias, last item closes it
	task automatic send_dot_product();
		int          len;
		logic [31:0] bias;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
		case ($urandom_range(0, 3))
			0, 1: bias = 32'($urandom_range(0, 8191)) - 32'd4096;
			2: bias = 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
			default: bias = $urandom();
		endcase
		for (int i = 0; i < len; i++)
			send_pair(8'($urandom()), 8'($urandom()), (i == 0) ? bias : $urandom(),
				i == 0, i == len - 1, 1'b0, 16'h0000);
	endtask

	// Receiver backpressure
	always @(negedge clk) begin
		results_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, expected none, actual %h",
					$time, results_ch.result);
			end else begin
				oldest = pending_results.pop_front();
				if (results_ch.result !== oldest) begin
					mismatches++;
					$display("%0t: result mismatch, expected %h, actual %h",
						$time, oldest, results_ch.result);
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((pairs_ch.valid && pairs_ch.ready) || (results_ch.valid && results_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, stall_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = 3'd0;
		cfg_data              = 32'd0;
		pairs_ch.valid        = 1'b0;
		pairs_ch.activation   = 8'd0;
		pairs_ch.weight       = 8'd0;
		pairs_ch.channel_bias = 32'd0;
		pairs_ch.first        = 1'b0;
		pairs_ch.last         = 1'b0;
		results_ch.ready      = 1'b0;
		zp_input              = 8'd0;
		zp_weight             = 8'd0;
		zp_result             = 8'd0;
		scale_mult            = 32'sh4000_0000;
		scale_shift           = 6'd0;
		clamp_lo              = 8'd0;
		clamp_hi              = 8'd255;
		byte_mode             = 1'b1;
		acc_model             = 32'd0;
		mismatches            = 0;
		items_sent            = 0;
		results_seen          = 0;
		settings_used         = 1;
		stall_cycles          = 0;
		src_idle_pct          = 36;
		snk_idle_pct          = 45;

		// Defaults give (acc + 1) / 2 rounded down, saturated to a byte
		directed_plan = '{
			pair_row(8'd0, 8'd0, 32'd0, 1, 1, 1, 16'h0000),
			pair_row(8'd255, 8'd255, 32'd0, 1, 1, 1, 16'h00FF),
			pair_row(8'd0, 8'd0, -32'sd1000, 1, 1, 1, 16'h0000),
			pair_row(8'd1, 8'd1, 32'd20, 1, 1, 1, 16'h000B),
			// no first flag: keeps adding to the previous sum
			pair_row(8'd2, 8'd3, 32'd999, 0, 1),
			// accumulator wraps past the int32 top
			pair_row(8'd10, 8'd10, 32'h7FFF_FFFF, 1, 0),
			pair_row(8'd10, 8'd10, 32'd0, 0, 1),
			pair_row(8'd0, 8'd0, 32'd510, 1, 1, 1, 16'h00FF),
			pair_row(8'd0, 8'd0, 32'd508, 1, 1, 1, 16'h00FE),
			pair_row(8'd200, 8'd100, 32'd5, 1, 0),
			pair_row(8'd3, 8'd7, 32'd77, 0, 0),
			pair_row(8'd1, 8'd1, 32'd0, 0, 1),
			// int16 mode, both operands at the int32 minimum saturate the multiply
			write_row(qdpr_pkg::REG_NARROW_TO_BYTE, 32'd0),
			write_row(qdpr_pkg::REG_SCALE_MULTIPLIER, 32'h8000_0000),
			pair_row(8'd0, 8'd0, 32'h8000_0000, 1, 1, 1, 16'h7FFF),
			// shift of minus thirty-two acts as a left shift by 31
			write_row(qdpr_pkg::REG_SCALE_MULTIPLIER, 32'h4000_0000),
			write_row(qdpr_pkg::REG_SCALE_SHIFT, 32'h20),
			pair_row(8'd0, 8'd0, 32'd3, 1, 1, 1, 16'h7FFF),
			pair_row(8'd0, 8'd0, -32'sd3, 1, 1, 1, 16'h8000),
			write_row(qdpr_pkg::REG_SCALE_SHIFT, 32'd31),
			write_row(qdpr_pkg::REG_SCALE_MULTIPLIER, 32'h7FFF_FFFF),
			pair_row(8'd255, 8'd255, 32'h7FFF_FFFF, 1, 1),
			// crossed clamp bounds give the high bound
			write_row(qdpr_pkg::REG_NARROW_TO_BYTE, 32'd1),
			write_row(qdpr_pkg::REG_CLAMP_LOW, 32'd200),
			write_row(qdpr_pkg::REG_CLAMP_HIGH, 32'd100),
			write_row(qdpr_pkg::REG_SCALE_SHIFT, 32'd0),
			write_row(qdpr_pkg::REG_SCALE_MULTIPLIER, 32'h4000_0000),
			pair_row(8'd0, 8'd0, 32'd0, 1, 1, 1, 16'h0064),
			// all zero points at the top
			write_row(qdpr_pkg::REG_INPUT_OFFSET, 32'd255),
			write_row(qdpr_pkg::REG_WEIGHT_OFFSET, 32'd255),
			write_row(qdpr_pkg::REG_RESULT_OFFSET, 32'd255),
			write_row(qdpr_pkg::REG_CLAMP_LOW, 32'd0),
			write_row(qdpr_pkg::REG_CLAMP_HIGH, 32'd255),
			pair_row(8'd0, 8'd0, 32'd0, 1, 1),
			pair_row(8'd255, 8'd0, -32'sd200, 1, 1),
			pair_row(8'd254, 8'd0, 32'd0, 1, 1)
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_write) begin
				settle();
				write_reg(directed_plan[i].index, directed_plan[i].data);
			end else begin
				send_pair(directed_plan[i].activation, directed_plan[i].weight,
					directed_plan[i].bias, directed_plan[i].first, directed_plan[i].last,
					directed_plan[i].typed, directed_plan[i].typed_result);
			end
		end
		directed_items = items_sent;

		// Random part: three idle mixes, three register settings each
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
			snk_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 36 : 0;
			for (int seg = 0; seg < 3; seg++) begin
				if (phase == 0 && seg == 0)
					apply_settings(SET_LOWEST);
				else if (phase == 0 && seg == 1)
					apply_settings(SET_HIGHEST);
				else
					apply_settings(SET_RANDOM);
				seg_start = items_sent;
				while (items_sent - seg_start < SEGMENT_ITEMS) begin
					if ($urandom_range(0, 7) == 0)
						send_pair(8'($urandom()), 8'($urandom()), $urandom(),
							1'($urandom()), 1'($urandom()), 1'b0, 16'h0000);
					else
						send_dot_product();
				end
			end
		end

		settle();
		$display("Run covered %0d items (%0d directed) under %0d register settings, %0d results.",
			items_sent, directed_items, settings_used, results_seen);
		$display("Both output modes, shifts from -32 to 31, crossed clamps, three idle mixes.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: quantized_dot_product_requantize.f
src/qdpr_pkg.sv
src/qdpr_if.sv
src/qdpr_front.sv
src/qdpr_fifo.sv
src/qdpr_requant.sv
src/quantized_dot_product_requantize.sv
tb/testbench.sv
